>>> src/gsgs_pkg.sv
// Shared types and constants of the grid solver.
`timescale 1ns / 1ps
package gsgs_pkg;

  localparam int IDX_BITS   = 5;
  localparam int DATA_BITS  = 32;
  localparam int INV_BITS   = 16;
  localparam int COUNT_BITS = 8;
  localparam int REG_BITS   = 3;
  localparam int FRAC_SHIFT = 16;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_READ  = 2'd2
  } gsgs_action_e;

  typedef enum logic [REG_BITS-1:0] {
    REG_SWEEP_COUNT = 3'd0,
    REG_GRID_COLS   = 3'd1,
    REG_GRID_ROWS   = 3'd2,
    REG_INV_DENOM   = 3'd3,
    REG_SOURCE_TERM = 3'd4
  } gsgs_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RD_NS,
    ST_RD_EW,
    ST_SUM,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } gsgs_state_e;

  typedef struct packed {
    logic [1:0]                  action;
    logic [IDX_BITS-1:0]         col_index;
    logic [IDX_BITS-1:0]         row_index;
    logic signed [DATA_BITS-1:0] point_value;
  } gsgs_in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] read_value;
    logic                        status;
  } gsgs_out_t;

  typedef struct packed {
    logic [REG_BITS-1:0]  index;
    logic [DATA_BITS-1:0] data;
  } gsgs_cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]       sweep_count;
    logic [IDX_BITS-1:0]         grid_cols;
    logic [IDX_BITS-1:0]         grid_rows;
    logic [INV_BITS-1:0]         inv_denominator;
    logic signed [DATA_BITS-1:0] source_term;
  } gsgs_regs_t;

  typedef struct packed {
    logic ns_en;
    logic diff_en;
    logic prod_en;
  } gsgs_alu_ctrl_t;

endpackage

>>> src/gsgs_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
`timescale 1ns / 1ps
interface gsgs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/gsgs_grid_mem.sv
// Grid store: one write port, two registered read ports.
`timescale 1ns / 1ps
module gsgs_grid_mem #(
  parameter int DEPTH      = 1024,
  parameter int WIDTH      = 32,
  parameter int ADDR_BITS  = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ADDR_BITS-1:0]    waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [ADDR_BITS-1:0]    raddr_a_i,
  input  logic [ADDR_BITS-1:0]    raddr_b_i,
  output logic signed [WIDTH-1:0] rdata_a_o,
  output logic signed [WIDTH-1:0] rdata_b_o
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

>>> src/gsgs_stencil_alu.sv
// Five-point update datapath: neighbor sum, source subtract, scale, round, saturate.
`timescale 1ns / 1ps
module gsgs_stencil_alu #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  gsgs_pkg::gsgs_alu_ctrl_t             ctrl_i,
  input  logic signed [VALUE_BITS-1:0]         rdata_a_i,
  input  logic signed [VALUE_BITS-1:0]         rdata_b_i,
  input  logic signed [gsgs_pkg::DATA_BITS-1:0] source_term_i,
  input  logic [gsgs_pkg::INV_BITS-1:0]        inv_i,
  output logic signed [VALUE_BITS-1:0]         result_o
);
  import gsgs_pkg::*;

  localparam int PAIR_BITS = VALUE_BITS + 1;
  localparam int SUM_BITS  = VALUE_BITS + 2;
  localparam int DIFF_BITS = ((SUM_BITS > DATA_BITS) ? SUM_BITS : DATA_BITS) + 1;
  localparam int PROD_BITS = DIFF_BITS + INV_BITS + 1;
  localparam int SH_BITS   = PROD_BITS - FRAC_SHIFT;

  localparam logic signed [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [SH_BITS-1:0] VMAX =
    {{(SH_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [SH_BITS-1:0] VMIN = ~VMAX;

  logic signed [PAIR_BITS-1:0] ns_q;
  logic signed [DIFF_BITS-1:0] diff_d, diff_q;
  logic signed [PROD_BITS-1:0] prod_d, prod_q;
  logic signed [PROD_BITS-1:0] rounded;
  logic signed [SH_BITS-1:0]   scaled;

  always_comb begin
    diff_d = DIFF_BITS'(ns_q) + DIFF_BITS'(rdata_a_i) + DIFF_BITS'(rdata_b_i)
           - DIFF_BITS'(source_term_i);
    prod_d = diff_q * $signed({1'b0, inv_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ns_en) begin
      ns_q <= PAIR_BITS'(rdata_a_i) + PAIR_BITS'(rdata_b_i);
    end
    if (ctrl_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    rounded = prod_q + HALF_LSB;
    scaled  = SH_BITS'(rounded >>> FRAC_SHIFT);
    if (scaled > VMAX) begin
      result_o = VALUE_BITS'(VMAX);
    end else if (scaled < VMIN) begin
      result_o = VALUE_BITS'(VMIN);
    end else begin
      result_o = VALUE_BITS'(scaled);
    end
  end

endmodule

>>> src/gsgs_sequencer.sv
// Item decode, sweep sequencing, grid addressing and result register.
`timescale 1ns / 1ps
module gsgs_sequencer #(
  parameter int SIDE_MAX   = 32,
  parameter int VALUE_BITS = 32,
  parameter int ADDR_BITS  = $clog2(SIDE_MAX * SIDE_MAX)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gsgs_pkg::gsgs_regs_t          regs_i,
  gsgs_stream_if.sink                   in_i,
  gsgs_stream_if.source                 out_o,
  output logic                          mem_we_o,
  output logic [ADDR_BITS-1:0]          mem_waddr_o,
  output logic signed [VALUE_BITS-1:0]  mem_wdata_o,
  output logic                          mem_re_o,
  output logic [ADDR_BITS-1:0]          mem_raddr_a_o,
  output logic [ADDR_BITS-1:0]          mem_raddr_b_o,
  input  logic signed [VALUE_BITS-1:0]  mem_rdata_a_i,
  output gsgs_pkg::gsgs_alu_ctrl_t      alu_ctrl_o,
  input  logic signed [VALUE_BITS-1:0]  alu_result_i
);
  import gsgs_pkg::*;

  localparam int EXT_BITS = (VALUE_BITS > DATA_BITS) ? VALUE_BITS : DATA_BITS;
  localparam logic signed [EXT_BITS-1:0] VMAX_V =
    {{(EXT_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [EXT_BITS-1:0] VMIN_V = ~VMAX_V;
  localparam logic signed [EXT_BITS-1:0] VMAX_D =
    {{(EXT_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [EXT_BITS-1:0] VMIN_D = ~VMAX_D;

  gsgs_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] sweep_q, sweep_d;
  logic [IDX_BITS-1:0]   row_q, row_d;
  logic [IDX_BITS-1:0]   col_q, col_d;
  logic                  out_valid_q, out_valid_d;
  gsgs_out_t             out_q, out_d;

  logic                        accept;
  logic                        slot_free;
  logic                        out_range;
  logic                        no_work;
  logic                        col_last, row_last, sweep_last;
  logic signed [EXT_BITS-1:0]  wr_ext, rd_ext;
  logic signed [VALUE_BITS-1:0] wr_sat;
  logic signed [DATA_BITS-1:0]  rd_sat;

  function automatic logic [ADDR_BITS-1:0] grid_addr(input logic [IDX_BITS-1:0] row,
                                                     input logic [IDX_BITS-1:0] col);
    int lin;
    lin = (int'(row) % SIDE_MAX) * SIDE_MAX + (int'(col) % SIDE_MAX);
    return ADDR_BITS'(lin);
  endfunction

  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && slot_free && (state_q == ST_IDLE);
  assign out_range = (in_i.payload.col_index > regs_i.grid_cols) ||
                     (in_i.payload.row_index > regs_i.grid_rows);
  assign no_work   = (regs_i.sweep_count == '0) || (regs_i.grid_cols < IDX_BITS'(2)) ||
                     (regs_i.grid_rows < IDX_BITS'(2));
  assign col_last   = ({1'b0, col_q} + 6'd1) == {1'b0, regs_i.grid_cols};
  assign row_last   = ({1'b0, row_q} + 6'd1) == {1'b0, regs_i.grid_rows};
  assign sweep_last = ({1'b0, sweep_q} + 9'd1) == {1'b0, regs_i.sweep_count};

  always_comb begin
    wr_ext = EXT_BITS'(in_i.payload.point_value);
    if (wr_ext > VMAX_V) begin
      wr_sat = VALUE_BITS'(VMAX_V);
    end else if (wr_ext < VMIN_V) begin
      wr_sat = VALUE_BITS'(VMIN_V);
    end else begin
      wr_sat = VALUE_BITS'(wr_ext);
    end
    rd_ext = EXT_BITS'(mem_rdata_a_i);
    if (rd_ext > VMAX_D) begin
      rd_sat = DATA_BITS'(VMAX_D);
    end else if (rd_ext < VMIN_D) begin
      rd_sat = DATA_BITS'(VMIN_D);
    end else begin
      rd_sat = DATA_BITS'(rd_ext);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.payload.action == ACT_READ && !out_range) begin
            state_d = ST_READ;
          end else if (in_i.payload.action == ACT_SOLVE) begin
            state_d = no_work ? ST_DONE : ST_RD_NS;
          end
        end
      end
      ST_READ:  if (slot_free) state_d = ST_IDLE;
      ST_RD_NS: state_d = ST_RD_EW;
      ST_RD_EW: state_d = ST_SUM;
      ST_SUM:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = (col_last && row_last && sweep_last) ? ST_DONE : ST_RD_NS;
      end
      ST_DONE:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_i.ready    = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = grid_addr(row_q, col_q);
    mem_wdata_o   = alu_result_i;
    mem_re_o      = 1'b0;
    mem_raddr_a_o = grid_addr(in_i.payload.row_index, in_i.payload.col_index);
    mem_raddr_b_o = grid_addr(row_q, col_q);
    alu_ctrl_o    = '0;
    sweep_d       = sweep_q;
    row_d         = row_q;
    col_d         = col_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_d         = out_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = slot_free;
        if (accept) begin
          unique case (in_i.payload.action)
            ACT_WRITE: begin
              mem_we_o    = !out_range;
              mem_waddr_o = grid_addr(in_i.payload.row_index, in_i.payload.col_index);
              mem_wdata_o = wr_sat;
              out_valid_d = 1'b1;
              out_d       = '{read_value: '0, status: out_range};
            end
            ACT_READ: begin
              mem_re_o = !out_range;
              if (out_range) begin
                out_valid_d = 1'b1;
                out_d       = '{read_value: '0, status: STATUS_RANGE};
              end
            end
            ACT_SOLVE: begin
              sweep_d = '0;
              row_d   = IDX_BITS'(1);
              col_d   = IDX_BITS'(1);
            end
            default: begin
              out_valid_d = 1'b1;
              out_d       = '{read_value: '0, status: STATUS_OK};
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{read_value: rd_sat, status: STATUS_OK};
        end
      end
      ST_RD_NS: begin
        mem_re_o      = 1'b1;
        mem_raddr_a_o = grid_addr(row_q - IDX_BITS'(1), col_q);
        mem_raddr_b_o = grid_addr(row_q + IDX_BITS'(1), col_q);
      end
      ST_RD_EW: begin
        mem_re_o         = 1'b1;
        mem_raddr_a_o    = grid_addr(row_q, col_q - IDX_BITS'(1));
        mem_raddr_b_o    = grid_addr(row_q, col_q + IDX_BITS'(1));
        alu_ctrl_o.ns_en = 1'b1;
      end
      ST_SUM: alu_ctrl_o.diff_en = 1'b1;
      ST_MUL: alu_ctrl_o.prod_en = 1'b1;
      ST_WRITE: begin
        mem_we_o = 1'b1;
        if (!col_last) begin
          col_d = col_q + IDX_BITS'(1);
        end else begin
          col_d = IDX_BITS'(1);
          if (!row_last) begin
            row_d = row_q + IDX_BITS'(1);
          end else begin
            row_d   = IDX_BITS'(1);
            sweep_d = sweep_q + COUNT_BITS'(1);
          end
        end
      end
      ST_DONE: begin
        sweep_d = '0;
        row_d   = '0;
        col_d   = '0;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{read_value: '0, status: STATUS_OK};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

>>> src/gauss_seidel_grid_solver.sv
// Write, no-op and out-of-range read items go straight to the result register;
// in-range reads pass ST_READ first, and solve items make sweep_count sweeps in which
// each interior point passes read-neighbors, sum, multiply and write-back in turn.
// One item is in flight at a time; a new item is taken once the waiting result leaves.
// Reset returns the registers to their defaults and idles the sequencer;
// the grid store is not cleared and must be written before use.
`timescale 1ns / 1ps
module gauss_seidel_grid_solver #(
  parameter int SIDE_MAX   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gsgs_stream_if.sink   cfg_i,
  gsgs_stream_if.sink   in_i,
  gsgs_stream_if.source out_o
);
  import gsgs_pkg::*;

  localparam int DEPTH     = SIDE_MAX * SIDE_MAX;
  localparam int ADDR_BITS = $clog2(DEPTH);

  gsgs_regs_t     regs_q;
  gsgs_alu_ctrl_t alu_ctrl;

  logic                         mem_we;
  logic [ADDR_BITS-1:0]         mem_waddr;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic                         mem_re;
  logic [ADDR_BITS-1:0]         mem_raddr_a;
  logic [ADDR_BITS-1:0]         mem_raddr_b;
  logic signed [VALUE_BITS-1:0] mem_rdata_a;
  logic signed [VALUE_BITS-1:0] mem_rdata_b;
  logic signed [VALUE_BITS-1:0] alu_result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.sweep_count     <= COUNT_BITS'(20);
      regs_q.grid_cols       <= IDX_BITS'(8);
      regs_q.grid_rows       <= IDX_BITS'(8);
      regs_q.inv_denominator <= INV_BITS'(14926);
      regs_q.source_term     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_SWEEP_COUNT: regs_q.sweep_count     <= cfg_i.payload.data[COUNT_BITS-1:0];
        REG_GRID_COLS:   regs_q.grid_cols       <= cfg_i.payload.data[IDX_BITS-1:0];
        REG_GRID_ROWS:   regs_q.grid_rows       <= cfg_i.payload.data[IDX_BITS-1:0];
        REG_INV_DENOM:   regs_q.inv_denominator <= cfg_i.payload.data[INV_BITS-1:0];
        REG_SOURCE_TERM: regs_q.source_term     <= $signed(cfg_i.payload.data);
        default: ;
      endcase
    end
  end

  gsgs_sequencer #(
    .SIDE_MAX   (SIDE_MAX),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_sequencer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .regs_i        (regs_q),
    .in_i          (in_i),
    .out_o         (out_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .alu_ctrl_o    (alu_ctrl),
    .alu_result_i  (alu_result)
  );

  gsgs_grid_mem #(
    .DEPTH     (DEPTH),
    .WIDTH     (VALUE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_grid_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  gsgs_stencil_alu #(
    .VALUE_BITS (VALUE_BITS)
  ) u_stencil_alu (
    .clk_i         (clk_i),
    .ctrl_i        (alu_ctrl),
    .rdata_a_i     (mem_rdata_a),
    .rdata_b_i     (mem_rdata_b),
    .source_term_i (regs_q.source_term),
    .inv_i         (regs_q.inv_denominator),
    .result_o      (alu_result)
  );

endmodule
